// ===== rtl/core/drgf_pkg.sv =====
// ----------------------------------------------------------------------------
// drgf_pkg
// Shared types, register indexes, state codes and the spatial weight
// function of the depth range-gated Gaussian filter.
// ----------------------------------------------------------------------------
package drgf_pkg;

   localparam int DEPTH_W = 16;
   localparam int SIZE_W  = 11;
   localparam int CSR_IW  = 2;
   localparam int CSR_DW  = 16;

   localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST     = 11'd640;
   localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST    = 11'd480;
   localparam logic [DEPTH_W-1:0] RANGE_THRESHOLD_RST = 16'd100;

   // exp(-1/18) in Q0.32
   localparam logic [63:0] QSTEP = 64'd4062864982;

   typedef struct packed {
      logic               cmd;
      logic [DEPTH_W-1:0] depth_sample;
   } req_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] filtered_depth;
      logic               last_of_frame;
   } rsp_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_FRAME_WIDTH     = 2'd0,
      CSR_FRAME_HEIGHT    = 2'd1,
      CSR_RANGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CTR,
      ST_WIN,
      ST_DRAIN,
      ST_DIV,
      ST_DONE
   } state_type;

   // weight for squared distance k, 1.0 = 2^frac; elaboration only
   function automatic logic [31:0] weight_of(input int k, input int frac);
      logic [63:0] w;
      int          i;
      w = 64'd1 << 31;
      for (i = 0; i < k; i++) begin
         w = (w * QSTEP + (64'd1 << 31)) >> 32;
      end
      return 32'((w + (64'd1 << (30 - frac))) >> (31 - frac));
   endfunction

endpackage

// ===== rtl/core/depth_range_gated_gaussian_filter.sv =====
// ----------------------------------------------------------------------------
// depth_range_gated_gaussian_filter
// Depth smoothing with spatial Gaussian weights and a hard range cutoff.
// Rows live in a line store RAM; each result walks the window through it.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_data (cmd, depth_sample)
//  rsp     | out       | rsp_valid, rsp_ready, rsp_data (filtered_depth, last)
//  csr     | in        | csr_we, csr_index, csr_wdata
//
//  An item that yields no result is accepted with no filter pass. An item
//  that yields a result goes through accept, centre read, one line store read
//  per window tap (single read port), an accumulate drain, the divide and the
//  output step, which waits while the output register still holds a result.
//  Reset is synchronous; the line store needs no clearing.
//  The next item is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module depth_range_gated_gaussian_filter #(
   parameter int MAX_WIDTH        = 1024,
   parameter int MAX_HEIGHT       = 1024,
   parameter int RADIUS           = 6,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  drgf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output drgf_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [drgf_pkg::CSR_IW-1:0]     csr_index,
   input  logic [drgf_pkg::CSR_DW-1:0]     csr_wdata
);
   import drgf_pkg::*;

   localparam int SLOTS = 2 * RADIUS + 2;
   localparam int SLW   = $clog2(SLOTS);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int AW    = $clog2(SLOTS * MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT + RADIUS + 1);
   localparam int W1    = $clog2(MAX_WIDTH + 1);
   localparam int H1    = $clog2(MAX_HEIGHT + 1);
   localparam int WIN   = 2 * RADIUS + 1;
   localparam int OW    = $clog2(WIN);
   localparam int MRW   = $clog2(MAX_HEIGHT + 2 * RADIUS);
   localparam int KMAX  = 2 * RADIUS * RADIUS;
   localparam int KW    = $clog2(KMAX + 1);
   localparam int WW    = WEIGHT_FRAC_BITS + 1;
   localparam int NB    = $clog2(WIN * WIN + 1);
   localparam int SW    = WW + NB;
   localparam int SD    = SW + DEPTH_W;

   logic [WW-1:0] wtab [KMAX+1];
   for (genvar k = 0; k <= KMAX; k++) begin : g_wtab
      localparam logic [31:0] WK = weight_of(k, WEIGHT_FRAC_BITS);
      assign wtab[k] = WK[WW-1:0];
   end

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]  fw_ff, fw_in, fh_ff, fh_in;
   logic [DEPTH_W-1:0] thr_ff, thr_in;
   logic [W1-1:0]      act_w_ff, act_w_in;
   logic [H1-1:0]      act_h_ff, act_h_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [SLW-1:0]     wslot_ff, wslot_in;
   logic [H1-1:0]      crow_ff, crow_in;
   logic [CW-1:0]      ccol_ff, ccol_in;
   logic [SLW-1:0]     cslot_ff, cslot_in;
   logic               last_ff, last_in;
   logic [OW-1:0]      dyo_ff, dyo_in, dxo_ff, dxo_in;
   logic [SLW-1:0]     rslot_ff, rslot_in;
   logic [MRW-1:0]     mr_ff, mr_in;
   logic               cap_ff;
   logic [DEPTH_W-1:0] centre_ff;
   logic               t1_ff, t1_in, inb_ff, inb_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               t2_ff, t2_in;
   logic [WW+DEPTH_W-1:0] prod_ff;
   logic [WW-1:0]      wsel_ff;
   logic [SW-1:0]      sum_w_ff, sum_w_in;
   logic [SD-1:0]      sum_wd_ff, sum_wd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept, start_frame, out_need, c_last, wr_en, div_start, div_busy;
   logic [W1-1:0]      eff_w;
   logic [H1-1:0]      eff_h;
   int                 cw_i, ch_i, nc_i, dy_i, dx_i;
   logic [AW-1:0]      waddr, raddr;
   logic [DEPTH_W-1:0] rdata, diff;
   logic               hit;
   logic [15:0]        quo;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cw_i = int'(fw_ff);
      if (cw_i < RADIUS + 1) cw_i = RADIUS + 1;
      if (cw_i > MAX_WIDTH) cw_i = MAX_WIDTH;
      ch_i = int'(fh_ff);
      if (ch_i < 1) ch_i = 1;
      if (ch_i > MAX_HEIGHT) ch_i = MAX_HEIGHT;
   end

   assign start_frame = (row_ff == '0) && (col_ff == '0);
   assign eff_w    = start_frame ? W1'(cw_i) : act_w_ff;
   assign eff_h    = start_frame ? H1'(ch_i) : act_h_ff;
   assign wr_en    = accept && (int'(row_ff) < int'(eff_h));
   assign out_need = (int'(row_ff) > RADIUS) ||
                     ((int'(row_ff) == RADIUS) && (int'(col_ff) >= RADIUS));
   assign c_last   = (int'(crow_ff) == int'(eff_h) - 1) &&
                     (int'(ccol_ff) == int'(eff_w) - 1);
   assign waddr    = AW'(wslot_ff) * AW'(MAX_WIDTH) + AW'(col_ff);

   assign nc_i = int'(ccol_ff) + int'(dxo_ff);
   assign dy_i = int'(dyo_ff) - RADIUS;
   assign dx_i = int'(dxo_ff) - RADIUS;

   always_comb begin
      if (state_ff == ST_CTR) begin
         raddr = AW'(cslot_ff) * AW'(MAX_WIDTH) + AW'(ccol_ff);
      end else begin
         raddr = AW'(rslot_ff) * AW'(MAX_WIDTH) + AW'(CW'(nc_i - RADIUS));
      end
   end

   drgf_ram #(.WIDTH(DEPTH_W), .DEPTH(SLOTS * MAX_WIDTH)) u_line (
      .clock (clock),
      .we    (wr_en),
      .waddr (waddr),
      .wdata (req_data.cmd ? '0 : req_data.depth_sample),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign diff = (rdata > centre_ff) ? rdata - centre_ff : centre_ff - rdata;
   assign hit  = t1_ff && inb_ff && (rdata != '0) && (diff < thr_ff);

   assign div_start = (state_ff == ST_DRAIN) && !t1_ff && !t2_ff;

   drgf_div #(.NW(SD), .DW(SW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_wd_ff),
      .den   (sum_w_ff),
      .busy  (div_busy),
      .quo   (quo)
   );

   always_comb begin
      state_in     = state_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      thr_in       = thr_ff;
      act_w_in     = act_w_ff;
      act_h_in     = act_h_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wslot_in     = wslot_ff;
      crow_in      = crow_ff;
      ccol_in      = ccol_ff;
      cslot_in     = cslot_ff;
      last_in      = last_ff;
      dyo_in       = dyo_ff;
      dxo_in       = dxo_ff;
      rslot_in     = rslot_ff;
      mr_in        = mr_ff;
      t1_in        = 1'b0;
      inb_in       = 1'b0;
      k_in         = k_ff;
      t2_in        = hit;
      sum_w_in     = sum_w_ff;
      sum_wd_in    = sum_wd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:     fw_in  = csr_wdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT:    fh_in  = csr_wdata[SIZE_W-1:0];
            CSR_RANGE_THRESHOLD: thr_in = csr_wdata;
            default: ;
         endcase
      end

      if (t2_ff) begin
         sum_w_in  = sum_w_ff + SW'(wsel_ff);
         sum_wd_in = sum_wd_ff + SD'(prod_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_w_in = eff_w;
               act_h_in = eff_h;
               last_in  = c_last;
               if (out_need && c_last) begin
                  row_in   = '0;
                  col_in   = '0;
                  wslot_in = '0;
               end else if (int'(col_ff) + 1 == int'(eff_w)) begin
                  col_in   = '0;
                  row_in   = row_ff + RW'(1);
                  wslot_in = (int'(wslot_ff) == SLOTS - 1) ? '0 : wslot_ff + SLW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
               if (out_need) state_in = ST_CTR;
            end
         end
         ST_CTR: begin
            dyo_in    = '0;
            dxo_in    = '0;
            mr_in     = MRW'(crow_ff);
            rslot_in  = (int'(cslot_ff) >= RADIUS) ? SLW'(int'(cslot_ff) - RADIUS)
                                                   : SLW'(int'(cslot_ff) + SLOTS - RADIUS);
            sum_w_in  = '0;
            sum_wd_in = '0;
            state_in  = ST_WIN;
         end
         ST_WIN: begin
            t1_in  = 1'b1;
            inb_in = (int'(mr_ff) >= RADIUS) &&
                     (int'(mr_ff) < int'(act_h_ff) + RADIUS) &&
                     (nc_i >= RADIUS) && (nc_i < int'(act_w_ff) + RADIUS);
            k_in   = KW'(dy_i * dy_i + dx_i * dx_i);
            if (int'(dxo_ff) == WIN - 1) begin
               dxo_in   = '0;
               dyo_in   = dyo_ff + OW'(1);
               mr_in    = mr_ff + MRW'(1);
               rslot_in = (int'(rslot_ff) == SLOTS - 1) ? '0 : rslot_ff + SLW'(1);
               if (int'(dyo_ff) == WIN - 1) state_in = ST_DRAIN;
            end else begin
               dxo_in = dxo_ff + OW'(1);
            end
         end
         ST_DRAIN: begin
            if (div_start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.filtered_depth  = (sum_w_ff == '0) ? '0 : quo;
               rsp_data_in.last_of_frame   = last_ff;
               if (last_ff) begin
                  crow_in  = '0;
                  ccol_in  = '0;
                  cslot_in = '0;
               end else if (int'(ccol_ff) + 1 == int'(act_w_ff)) begin
                  ccol_in  = '0;
                  crow_in  = crow_ff + H1'(1);
                  cslot_in = (int'(cslot_ff) == SLOTS - 1) ? '0 : cslot_ff + SLW'(1);
               end else begin
                  ccol_in = ccol_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fw_ff        <= FRAME_WIDTH_RST;
         fh_ff        <= FRAME_HEIGHT_RST;
         thr_ff       <= RANGE_THRESHOLD_RST;
         act_w_ff     <= W1'(640);
         act_h_ff     <= H1'(480);
         row_ff       <= '0;
         col_ff       <= '0;
         wslot_ff     <= '0;
         crow_ff      <= '0;
         ccol_ff      <= '0;
         cslot_ff     <= '0;
         t1_ff        <= 1'b0;
         t2_ff        <= 1'b0;
         cap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         thr_ff       <= thr_in;
         act_w_ff     <= act_w_in;
         act_h_ff     <= act_h_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         wslot_ff     <= wslot_in;
         crow_ff      <= crow_in;
         ccol_ff      <= ccol_in;
         cslot_ff     <= cslot_in;
         t1_ff        <= t1_in;
         t2_ff        <= t2_in;
         cap_ff       <= (state_ff == ST_CTR);
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff   <= last_in;
      dyo_ff    <= dyo_in;
      dxo_ff    <= dxo_in;
      rslot_ff  <= rslot_in;
      mr_ff     <= mr_in;
      inb_ff    <= inb_in;
      k_ff      <= k_in;
      wsel_ff   <= wtab[k_ff];
      prod_ff   <= wtab[k_ff] * rdata;
      sum_w_ff  <= sum_w_in;
      sum_wd_ff <= sum_wd_in;
      rsp_data_ff <= rsp_data_in;
      if (cap_ff) centre_ff <= rdata;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== rtl/core/drgf_ram.sv =====
// ----------------------------------------------------------------------------
// drgf_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module drgf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/drgf_div.sv =====
// ----------------------------------------------------------------------------
// drgf_div
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// Caller guarantees the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module drgf_div #(
   parameter int NW = 48,
   parameter int DW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [15:0]   quo
);
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dv_ff, dv_in;
   logic [15:0]   q_ff, q_in;
   logic [4:0]    cnt_ff, cnt_in;

   always_comb begin
      rem_in = rem_ff;
      dv_in  = dv_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = num;
         dv_in  = NW'(den) << 15;
         cnt_in = 5'd16;
      end else if (cnt_ff != 5'd0) begin
         if (rem_ff >= dv_ff) begin
            rem_in = rem_ff - dv_ff;
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            q_in   = {q_ff[14:0], 1'b0};
         end
         dv_in  = dv_ff >> 1;
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 5'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      q_ff   <= q_in;
   end

   assign busy = (cnt_ff != 5'd0);
   assign quo  = q_ff;
endmodule

// ===== rtl/core/drgf_checker.sv =====
// ----------------------------------------------------------------------------
// drgf_checker
// Port-level checks on the result channel of the depth filter.
// ----------------------------------------------------------------------------
module drgf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input drgf_pkg::rsp_type rsp_data
);
   import drgf_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a filter pass");

   a_no_accept_unless_valid: assert property (@(posedge clock) disable iff (reset)
      req_ready && !req_valid |=> !$rose(rsp_valid))
      else $error("result appeared with no item in work");
endmodule

bind depth_range_gated_gaussian_filter drgf_checker u_drgf_checker (.*);
